// ===== rtl/core/bb3_pkg.sv =====
package bb3_pkg;

  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 12;
  localparam int ROW_W      = 13;
  localparam int PSUM_W     = 10;
  localparam int SUM_W      = 12;
  localparam int CNT_W      = 4;
  localparam int RECIP_W    = 20;
  localparam int RECIP_SHIFT = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // One window column, top row first.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef struct packed {
    logic top;
    logic bot;
  } row_en_t;

  typedef struct packed {
    logic [PSUM_W-1:0] red;
    logic [PSUM_W-1:0] green;
    logic [PSUM_W-1:0] blue;
  } psum_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sum_t;

  function automatic logic [PSUM_W-1:0] add3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return PSUM_W'(a) + PSUM_W'(b) + PSUM_W'(c);
  endfunction

  function automatic logic [CNT_W-1:0] count_of(logic left, logic right, logic top, logic bot);
    logic [1:0] cols;
    logic [1:0] rows;
    cols = 2'd1 + 2'(left) + 2'(right);
    rows = 2'd1 + 2'(top) + 2'(bot);
    return CNT_W'(cols) * CNT_W'(rows);
  endfunction

  // ceil(2^RECIP_SHIFT / (2*count)), exact for every numerator below 2^13
  function automatic logic [RECIP_W-1:0] recip(logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] m;
    case (count)
      4'd1:    m = 20'd524288;
      4'd2:    m = 20'd262144;
      4'd3:    m = 20'd174763;
      4'd4:    m = 20'd131072;
      4'd6:    m = 20'd87382;
      4'd9:    m = 20'd58255;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/bb3_col_cell.sv =====
module bb3_col_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  bb3_pkg::col_t    col_i,
  input  logic            col_en_i,
  input  bb3_pkg::row_en_t row_en_i,
  output bb3_pkg::col_t    col_o,
  output bb3_pkg::psum_t   sum_o
);

  bb3_pkg::col_t col_q;
  bb3_pkg::pix_t top_m;
  bb3_pkg::pix_t bot_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

  // Drop rows that fall outside the frame.
  assign top_m = row_en_i.top ? col_q.top : '0;
  assign bot_m = row_en_i.bot ? col_q.bot : '0;

  always_comb begin
    sum_o = '0;
    if (col_en_i) begin
      sum_o.red   = bb3_pkg::add3(top_m.red,   col_q.mid.red,   bot_m.red);
      sum_o.green = bb3_pkg::add3(top_m.green, col_q.mid.green, bot_m.green);
      sum_o.blue  = bb3_pkg::add3(top_m.blue,  col_q.mid.blue,  bot_m.blue);
    end
  end

endmodule

// ===== rtl/core/bb3_mean_div.sv =====
module bb3_mean_div (
  input  logic [bb3_pkg::SUM_W-1:0] sum_i,
  input  logic [bb3_pkg::CNT_W-1:0] count_i,
  output logic [7:0]                mean_o
);

  localparam int NUM_W  = bb3_pkg::SUM_W + 1;
  localparam int PROD_W = NUM_W + bb3_pkg::RECIP_W;

  logic [NUM_W-1:0]  num;
  logic [PROD_W-1:0] prod;

  // Round half up: (2*sum + count) / (2*count), done as a reciprocal multiply.
  assign num    = {sum_i, 1'b0} + NUM_W'(count_i);
  assign prod   = PROD_W'(num) * PROD_W'(bb3_pkg::recip(count_i));
  assign mean_o = prod[bb3_pkg::RECIP_SHIFT +: 8];

endmodule

// ===== rtl/core/box_blur_3x3_edge_aware_top.sv =====
// Pipeline: a result reaches the output register through stages A, B and C after the item that
// releases it is accepted; output k is released by input item k + width + 1.
// Throughput: one item per cycle, set by one read and one write of each row
// store per item and the three-cell window chain; an output stall freezes the whole chain.
// Reset: width and height return to 1, positions and window clear to zero;
// row store contents stay undefined until written.
module box_blur_3x3_edge_aware_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [7:0]                     red_in_i,
  input  logic [7:0]                     green_in_i,
  input  logic [7:0]                     blue_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     red_out_o,
  output logic [7:0]                     green_out_o,
  output logic [7:0]                     blue_out_o,
  output logic                           frame_last_o
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W = ((COL_W > bb3_pkg::WIDTH_W) ? COL_W : bb3_pkg::WIDTH_W) + 1;
  localparam int ROW_W = bb3_pkg::ROW_W;
  localparam int OROW_W = bb3_pkg::HEIGHT_W;

  // Configuration
  logic [bb3_pkg::WIDTH_W-1:0]  image_width_q;
  logic [bb3_pkg::HEIGHT_W-1:0] image_height_q;
  logic [bb3_pkg::WIDTH_W-1:0]  eff_w;
  logic [bb3_pkg::HEIGHT_W-1:0] eff_h;
  logic                         cfg_hit;

  // Positions
  logic [COL_W-1:0]  in_col_q, in_col_d;
  logic [ROW_W-1:0]  in_row_q, in_row_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;
  logic [OROW_W-1:0] out_row_q, out_row_d;
  logic [CMP_W-1:0]  in_col_inc;
  logic [CMP_W-1:0]  out_col_inc;
  logic [OROW_W:0]   out_row_inc;
  logic              out_col_last, out_row_last, out_last;

  logic          adv, in_acc, pix_phase, proc, emit;
  bb3_pkg::pix_t pix_in;

  // Stage A: row store read
  logic                 a_vld_q;
  logic [COL_W-1:0]     a_col_q;
  bb3_pkg::pix_t        a_pix_q, a_top_q, a_mid_q;
  logic                 a_emit_q, a_left_q, a_right_q, a_last_q;
  bb3_pkg::row_en_t     a_rows_q;

  // Stage B: window
  logic                 b_vld_q;
  logic                 b_left_q, b_right_q, b_last_q;
  bb3_pkg::row_en_t     b_rows_q;
  logic                 shift;
  bb3_pkg::col_t        new_col, col2, col1;
  bb3_pkg::psum_t       psum0, psum1, psum2;
  bb3_pkg::sum_t        win_sum;

  // Stage C: sums
  logic                       c_vld_q;
  bb3_pkg::sum_t              c_sum_q;
  logic [bb3_pkg::CNT_W-1:0]  c_count_q;
  logic                       c_last_q;
  bb3_pkg::pix_t              mean;

  // Output register
  logic          out_valid_q;
  bb3_pkg::pix_t out_pix_q;
  logic          out_last_q;

  bb3_pkg::pix_t upper_mem [MAX_WIDTH];
  bb3_pkg::pix_t middle_mem [MAX_WIDTH];

  assign cfg_ready_o = 1'b1;
  assign cfg_hit = cfg_valid_i &&
                   (cfg_index_i == bb3_pkg::CFG_IMAGE_WIDTH ||
                    cfg_index_i == bb3_pkg::CFG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= bb3_pkg::WIDTH_W'(1);
      image_height_q <= bb3_pkg::HEIGHT_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bb3_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[bb3_pkg::WIDTH_W-1:0];
        bb3_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[bb3_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = image_width_q;
    if (image_width_q == '0) begin
      eff_w = bb3_pkg::WIDTH_W'(1);
    end else if (32'(image_width_q) > MAX_WIDTH) begin
      eff_w = bb3_pkg::WIDTH_W'(MAX_WIDTH);
    end
    eff_h = (image_height_q == '0) ? bb3_pkg::HEIGHT_W'(1) : image_height_q;
  end

  // The whole chain moves unless a finished result is held by the sink.
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;
  assign pix_phase  = in_row_q < ROW_W'(eff_h);
  // Drop drain items that arrive while pixels are still due.
  assign proc       = in_acc && !(pix_phase && cmd_i);
  assign pix_in     = pix_phase ? {red_in_i, green_in_i, blue_in_i} : '0;
  assign emit       = proc && (in_row_q >= ROW_W'(2) ||
                               (in_row_q == ROW_W'(1) && in_col_q != '0));

  assign in_col_inc   = CMP_W'(in_col_q) + CMP_W'(1);
  assign out_col_inc  = CMP_W'(out_col_q) + CMP_W'(1);
  assign out_row_inc  = (OROW_W + 1)'(out_row_q) + (OROW_W + 1)'(1);
  assign out_col_last = out_col_inc >= CMP_W'(eff_w);
  assign out_row_last = out_row_inc >= (OROW_W + 1)'(eff_h);
  assign out_last     = out_col_last && out_row_last;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (proc) begin
      if (in_col_inc >= CMP_W'(eff_w)) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
      end else begin
        in_col_d = in_col_inc[COL_W-1:0];
      end
    end
    if (emit) begin
      if (out_last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else if (out_col_last) begin
        out_col_d = '0;
        out_row_d = out_row_inc[OROW_W-1:0];
      end else begin
        out_col_d = out_col_inc[COL_W-1:0];
      end
    end
    if (cfg_hit) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // Row stores. The upper store takes the old middle entry from the stage A register,
  // not at the read; forward it when the next item reads the same column.
  always_ff @(posedge clk_i) begin
    if (proc) begin
      a_mid_q <= middle_mem[in_col_q];
      middle_mem[in_col_q] <= pix_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && a_vld_q) begin
      upper_mem[a_col_q] <= a_mid_q;
    end
    if (in_acc) begin
      if (a_vld_q && a_col_q == in_col_q) begin
        a_top_q <= a_mid_q;
      end else begin
        a_top_q <= upper_mem[in_col_q];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      c_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_vld_q     <= proc;
      b_vld_q     <= a_vld_q && a_emit_q;
      c_vld_q     <= b_vld_q;
      out_valid_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_col_q      <= in_col_q;
      a_pix_q      <= pix_in;
      a_emit_q     <= emit;
      a_rows_q.top <= out_row_q != '0;
      a_rows_q.bot <= !out_row_last;
      a_left_q     <= out_col_q != '0;
      a_right_q    <= !out_col_last;
      a_last_q     <= out_last;
    end
    if (shift) begin
      b_rows_q  <= a_rows_q;
      b_left_q  <= a_left_q;
      b_right_q <= a_right_q;
      b_last_q  <= a_last_q;
    end
    if (adv && b_vld_q) begin
      c_sum_q   <= win_sum;
      c_count_q <= bb3_pkg::count_of(b_left_q, b_right_q, b_rows_q.top, b_rows_q.bot);
      c_last_q  <= b_last_q;
    end
    if (adv && c_vld_q) begin
      out_pix_q  <= mean;
      out_last_q <= c_last_q;
    end
  end

  // Window: newest column enters cell 2 and moves toward cell 0.
  assign shift       = adv && a_vld_q;
  assign new_col.top = a_top_q;
  assign new_col.mid = a_mid_q;
  assign new_col.bot = a_pix_q;

  bb3_col_cell u_cell2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (shift),
    .col_i    (new_col),
    .col_en_i (b_right_q),
    .row_en_i (b_rows_q),
    .col_o    (col2),
    .sum_o    (psum2)
  );

  bb3_col_cell u_cell1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (shift),
    .col_i    (col2),
    .col_en_i (1'b1),
    .row_en_i (b_rows_q),
    .col_o    (col1),
    .sum_o    (psum1)
  );

  bb3_col_cell u_cell0 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (shift),
    .col_i    (col1),
    .col_en_i (b_left_q),
    .row_en_i (b_rows_q),
    .col_o    (),
    .sum_o    (psum0)
  );

  assign win_sum.red   = bb3_pkg::SUM_W'(psum0.red) + bb3_pkg::SUM_W'(psum1.red) +
                         bb3_pkg::SUM_W'(psum2.red);
  assign win_sum.green = bb3_pkg::SUM_W'(psum0.green) + bb3_pkg::SUM_W'(psum1.green) +
                         bb3_pkg::SUM_W'(psum2.green);
  assign win_sum.blue  = bb3_pkg::SUM_W'(psum0.blue) + bb3_pkg::SUM_W'(psum1.blue) +
                         bb3_pkg::SUM_W'(psum2.blue);

  bb3_mean_div u_div_red (
    .sum_i   (c_sum_q.red),
    .count_i (c_count_q),
    .mean_o  (mean.red)
  );

  bb3_mean_div u_div_green (
    .sum_i   (c_sum_q.green),
    .count_i (c_count_q),
    .mean_o  (mean.green)
  );

  bb3_mean_div u_div_blue (
    .sum_i   (c_sum_q.blue),
    .count_i (c_count_q),
    .mean_o  (mean.blue)
  );

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = out_pix_q.red;
  assign green_out_o  = out_pix_q.green;
  assign blue_out_o   = out_pix_q.blue;
  assign frame_last_o = out_last_q;

endmodule

// ===== tb/sv/box_blur_3x3_edge_aware_top_test.sv =====
`timescale 1ns / 100ps

module box_blur_3x3_edge_aware_top_test;

  localparam int          MAX_WIDTH    = 1024;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_WAIT  = 8;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned SIZE_PROBE   = 40;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;
  localparam logic [bb3_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    bb3_pkg::pix_t px;
    logic          last;
  } blur_res_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic                           cmd_i;
  logic [7:0]                     red_in_i;
  logic [7:0]                     green_in_i;
  logic [7:0]                     blue_in_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [7:0]                     red_out_o;
  logic [7:0]                     green_out_o;
  logic [7:0]                     blue_out_o;
  logic                           frame_last_o;

  // Blur predictor state
  logic [bb3_pkg::WIDTH_W-1:0]  reg_width;
  logic [bb3_pkg::HEIGHT_W-1:0] reg_height;
  bb3_pkg::pix_t                upper_row [MAX_WIDTH];
  bb3_pkg::pix_t                middle_row [MAX_WIDTH];
  bb3_pkg::pix_t                win [9];  // column slot * 3 + row slot
  int unsigned                  in_col, in_row, out_col, out_row;

  blur_res_t   blur_expected [$];
  int unsigned mismatches;
  int unsigned items_used, pixels_sent, drains_sent, ignored_sent;
  int unsigned results_seen, frames_done, cycle_count;
  bit          calm;

  box_blur_3x3_edge_aware_top #(
    .MAX_WIDTH(MAX_WIDTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .frame_last_o(frame_last_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned blur_width();
    if (reg_width == '0) return 1;
    if (reg_width > MAX_WIDTH) return MAX_WIDTH;
    return reg_width;
  endfunction

  function automatic int unsigned blur_height();
    return (reg_height == '0) ? 1 : reg_height;
  endfunction

  function automatic int unsigned frame_len();
    return blur_width() * blur_height() + blur_width() + 1;
  endfunction

  function automatic void restart_positions();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void clear_blur_state();
    int unsigned k;
    reg_width  = 1;
    reg_height = 1;
    for (k = 0; k < MAX_WIDTH; k++) begin
      upper_row[k]  = '0;
      middle_row[k] = '0;
    end
    for (k = 0; k < 9; k++) win[k] = '0;
    restart_positions();
  endfunction

  function automatic void apply_reg(logic [bb3_pkg::CFG_IDX_W-1:0] idx,
                                    logic [bb3_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      bb3_pkg::CFG_IMAGE_WIDTH: begin
        reg_width = val[bb3_pkg::WIDTH_W-1:0];
        restart_positions();
      end
      bb3_pkg::CFG_IMAGE_HEIGHT: begin
        reg_height = val[bb3_pkg::HEIGHT_W-1:0];
        restart_positions();
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] round_mean(int unsigned sum, int unsigned cnt);
    return 8'((2 * sum + cnt) / (2 * cnt));
  endfunction

  // Advance the window by one item; returns 0 when the item is dropped.
  function automatic bit blur_step(logic cmd, bb3_pkg::pix_t px);
    int unsigned   w, h, cs, rs, cnt, sr, sg, sb;
    bb3_pkg::pix_t top, mid, cur, p;
    bit            emit;
    blur_res_t     res;
    w = blur_width();
    h = blur_height();
    if (in_row < h && cmd == CMD_DRAIN) return 0;
    cur = (in_row < h) ? px : '0;
    top = upper_row[in_col];
    mid = middle_row[in_col];
    upper_row[in_col]  = mid;
    middle_row[in_col] = cur;
    for (cs = 0; cs < 3; cs++) begin
      win[cs]     = win[3 + cs];
      win[3 + cs] = win[6 + cs];
    end
    win[6] = top;
    win[7] = mid;
    win[8] = cur;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return 1;
    cnt = 0;
    sr  = 0;
    sg  = 0;
    sb  = 0;
    for (cs = 0; cs < 3; cs++) begin
      if (cs == 0 && out_col == 0) continue;
      if (cs == 2 && out_col + 1 >= w) continue;
      for (rs = 0; rs < 3; rs++) begin
        if (rs == 0 && out_row == 0) continue;
        if (rs == 2 && out_row + 1 >= h) continue;
        p = win[cs * 3 + rs];
        sr += p.red;
        sg += p.green;
        sb += p.blue;
        cnt++;
      end
    end
    res.px.red   = round_mean(sr, cnt);
    res.px.green = round_mean(sg, cnt);
    res.px.blue  = round_mean(sb, cnt);
    res.last     = (out_row + 1 >= h) && (out_col + 1 >= w);
    blur_expected.push_back(res);
    if (res.last) begin
      restart_positions();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1;
  endfunction

  function automatic bb3_pkg::pix_t rand_pix();
    logic [23:0] v;
    int unsigned k;
    for (k = 0; k < 3; k++) begin
      case ($urandom_range(7))
        0:       v[k*8 +: 8] = 8'h00;
        1:       v[k*8 +: 8] = 8'hFF;
        default: v[k*8 +: 8] = 8'($urandom_range(255));
      endcase
    end
    return v;
  endfunction

  // Called and returns at a falling edge; valid stays high for a follow-up item.
  task automatic send_item(logic cmd, bb3_pkg::pix_t px);
    bit in_frame;
    while (!calm && $urandom_range(99) < 24) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i      = cmd;
    {red_in_i, green_in_i, blue_in_i} = px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    in_frame = in_row < blur_height();
    if (blur_step(cmd, px)) begin
      items_used++;
      if (in_frame)
        pixels_sent++;
      else
        drains_sent++;
    end else begin
      ignored_sent++;
    end
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (blur_expected.size() != 0) @(negedge clk_i);
    repeat (SETTLE_WAIT) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [bb3_pkg::CFG_IDX_W-1:0] idx,
                           logic [bb3_pkg::CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Send the first n_items of a frame; noise adds stray drains and late pixels.
  task automatic send_frame(int unsigned n_items, bit noisy);
    int unsigned k, n_pix;
    n_pix = blur_width() * blur_height();
    for (k = 0; k < n_items; k++) begin
      if (k < n_pix) begin
        if (noisy && $urandom_range(7) == 0) send_item(CMD_DRAIN, rand_pix());
        send_item(CMD_PIXEL, rand_pix());
      end else begin
        send_item((noisy && $urandom_range(3) == 0) ? CMD_PIXEL : CMD_DRAIN, rand_pix());
      end
    end
  endtask

  // Reset leaves a 1x1 frame: stray drain, pixel, late pixel, drain.
  task automatic test_reset_state();
    send_item(CMD_DRAIN, 24'hFFFFFF);
    send_item(CMD_PIXEL, 24'hFF00FF);
    send_item(CMD_PIXEL, rand_pix());
    send_item(CMD_DRAIN, 24'h000000);
  endtask

  // Corners, edges and center of a 3x3 frame, then a one-pixel-wide frame.
  task automatic test_edge_counts();
    int unsigned   k;
    bb3_pkg::pix_t px;
    write_reg(bb3_pkg::CFG_IMAGE_WIDTH, 12'd3);
    write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 12'd3);
    for (k = 0; k < 9; k++) begin
      // an unused register index must not restart the frame
      if (k == 5) write_reg(CFG_UNUSED_IDX, 12'd2);
      case (k % 3)
        0:       px = 24'hFFFFFF;
        1:       px = 24'h000000;
        default: px = rand_pix();
      endcase
      send_item(CMD_PIXEL, px);
    end
    for (k = 0; k < 4; k++) send_item(CMD_DRAIN, rand_pix());
    write_reg(bb3_pkg::CFG_IMAGE_WIDTH, 12'd1);
    write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 12'd2);
    send_frame(frame_len(), 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned start, done, w, h, n;
    bit          restart_due;
    restart_due = 1'b1;
    start       = items_used;
    done        = 0;
    while (done < RANDOM_ITEMS) begin
      calm = (done >= 300 && done < 450);
      if (restart_due || $urandom_range(2) == 0) begin
        case ($urandom_range(19))
          0:         w = $urandom_range(80, 41);
          1, 2, 3, 4: w = $urandom_range(40, 7);
          default:   w = $urandom_range(6, 1);
        endcase
        h = ($urandom_range(4) == 0) ? $urandom_range(12, 6) : $urandom_range(5, 1);
        case ($urandom_range(3))
          0: write_reg(bb3_pkg::CFG_IMAGE_WIDTH, 12'(w));
          1: write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 12'(h));
          2: begin
            write_reg(bb3_pkg::CFG_IMAGE_WIDTH, 12'(w));
            write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 12'(h));
          end
          default: begin
            write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 12'(h));
            write_reg(bb3_pkg::CFG_IMAGE_WIDTH, 12'(w));
          end
        endcase
        restart_due = 1'b0;
      end
      n = frame_len();
      if ($urandom_range(9) == 0) begin
        // cut the frame short; only a register write restarts it
        n = $urandom_range(n - 1, 0);
        restart_due = 1'b1;
      end
      if (n > RANDOM_ITEMS - done) begin
        n = RANDOM_ITEMS - done;
        restart_due = 1'b1;
      end
      send_frame(n, $urandom_range(3) == 0);
      done = items_used - start;
    end
    calm = 1'b0;
  endtask

  // Clamped width and the tallest frame, both cut short, then zero register values.
  task automatic test_size_limits();
    write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 12'd2);
    write_reg(bb3_pkg::CFG_IMAGE_WIDTH, 12'hFFF);
    send_frame(SIZE_PROBE, 1'b1);
    write_reg(bb3_pkg::CFG_IMAGE_WIDTH, 12'd1);
    write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 12'hFFF);
    send_frame(SIZE_PROBE, 1'b1);
    write_reg(bb3_pkg::CFG_IMAGE_WIDTH, 12'd0);
    write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 12'd0);
    send_frame(frame_len(), 1'b1);
  endtask

  always @(negedge clk_i) begin
    out_stall_i = rst_ni && !calm && ($urandom_range(99) < 24);
  end

  function automatic void report_field(string name, logic [7:0] want, logic [7:0] got);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
  endfunction

  always @(posedge clk_i) begin : check_results
    blur_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (frame_last_o === 1'b1) frames_done++;
      if (blur_expected.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected blurred pixel, expected none, actual %h/%b", $time,
                 {red_out_o, green_out_o, blue_out_o}, frame_last_o);
      end else begin
        want = blur_expected.pop_front();
        if (red_out_o !== want.px.red) report_field("red_out", want.px.red, red_out_o);
        if (green_out_o !== want.px.green) report_field("green_out", want.px.green, green_out_o);
        if (blue_out_o !== want.px.blue) report_field("blue_out", want.px.blue, blue_out_o);
        if (frame_last_o !== want.last) report_field("frame_last", 8'(want.last), 8'(frame_last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               blur_expected.size());
      $display("** box_blur_3x3_edge_aware_top: FAILED **");
      $finish;
    end
  end

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    cmd_i        = CMD_PIXEL;
    red_in_i     = '0;
    green_in_i   = '0;
    blue_in_i    = '0;
    out_stall_i  = 1'b0;
    calm         = 1'b0;
    mismatches   = 0;
    items_used   = 0;
    pixels_sent  = 0;
    drains_sent  = 0;
    ignored_sent = 0;
    results_seen = 0;
    frames_done  = 0;
    cycle_count  = 0;
    clear_blur_state();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_edge_counts();
    test_random_frames();
    test_size_limits();

    wait_idle();
    repeat (20) @(negedge clk_i);
    $display("Sent %0d items (%0d pixels, %0d drains or late pixels, %0d stray drains)",
             items_used + ignored_sent, pixels_sent, drains_sent, ignored_sent);
    $display("Checked %0d blurred pixels over %0d completed frames, %0d mismatches",
             results_seen, frames_done, mismatches);
    if (mismatches == 0) begin
      $display("** box_blur_3x3_edge_aware_top: PASSED **");
    end else begin
      $display("** box_blur_3x3_edge_aware_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bb3_pkg.sv
rtl/core/bb3_col_cell.sv
rtl/core/bb3_mean_div.sv
rtl/core/box_blur_3x3_edge_aware_top.sv
tb/sv/box_blur_3x3_edge_aware_top_test.sv
